FILE: design/ttc_pkg.sv
// shared constants, types and the cordic angle table for the tunnel coordinate block
package ttc_pkg;

	localparam int TexSize    = 256;
	localparam int CoordRange = 2048;
	localparam int TexW       = $clog2(TexSize);
	localparam int CoordW     = $clog2(CoordRange);
	localparam int CfgW       = 11;
	localparam int CfgIdxW    = 2;
	localparam int Steps      = 23;
	localparam int AngW       = 25;
	localparam int AngHalfTurn = 8388608;
	localparam int AngQuarter  = 4194304;
	localparam int AngEighth   = 2097152;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_HALF_WIDTH      = 2'd0,
		REG_HALF_HEIGHT     = 2'd1,
		REG_DISTANCE_OFFSET = 2'd2,
		REG_ANGLE_OFFSET    = 2'd3
	} cfg_reg_t;

	// octant case picked in the second stage
	typedef enum logic [2:0] {
		OCT_ZERO, OCT_AXIS_X, OCT_AXIS_Y, OCT_DIAG, OCT_LOW, OCT_HIGH
	} oct_t;

	// atan(2^-i) in units of pi/2^23
	function automatic logic [22:0] atan_unit(input int i);
		case (i)
			0: atan_unit = 23'd2097152;
			1: atan_unit = 23'd1238021;
			2: atan_unit = 23'd654136;
			3: atan_unit = 23'd332050;
			4: atan_unit = 23'd166669;
			5: atan_unit = 23'd83416;
			6: atan_unit = 23'd41718;
			7: atan_unit = 23'd20860;
			8: atan_unit = 23'd10430;
			9: atan_unit = 23'd5215;
			10: atan_unit = 23'd2608;
			11: atan_unit = 23'd1304;
			12: atan_unit = 23'd652;
			13: atan_unit = 23'd326;
			14: atan_unit = 23'd163;
			15: atan_unit = 23'd81;
			16: atan_unit = 23'd41;
			17: atan_unit = 23'd20;
			18: atan_unit = 23'd10;
			19: atan_unit = 23'd5;
			20: atan_unit = 23'd3;
			21: atan_unit = 23'd1;
			22: atan_unit = 23'd1;
			default: atan_unit = 23'd0;
		endcase
	endfunction

endpackage

FILE: design/tunnel_texture_coordinates.sv
// tunnel effect texture coordinate pipeline: centering, square root and cordic angle
// One pixel request enters per clock while nothing stalls, and its texture coordinates leave
// from the output stage. The pipe has 26 register stages: centering, octant fold with the
// squared radius, one cordic iteration per stage (23 stages) and the output
// stage with clamp, unfold, scale and offsets; the integer square root runs in parallel in
// the first 13 cordic stages, one result bit per stage.
// The whole pipe advances as long as the output stage is empty or being taken, so a
// stall on the result side holds every stage. The offsets are added at the output, so
// offset writes apply to pixels leaving after the write.
module tunnel_texture_coordinates #(
	parameter int TEX_SIZE    = ttc_pkg::TexSize,
	parameter int COORD_RANGE = ttc_pkg::CoordRange
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ttc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [ttc_pkg::CfgW-1:0]        cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [$clog2(COORD_RANGE)-1:0]  column,
	input  logic [$clog2(COORD_RANGE)-1:0]  row,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [$clog2(TEX_SIZE)-1:0]     texture_row,
	output logic [$clog2(TEX_SIZE)-1:0]     texture_column
);
	import ttc_pkg::*;

	localparam int TW   = $clog2(TEX_SIZE);
	localparam int CW   = $clog2(COORD_RANGE);
	localparam int DW   = CW + 2;            // signed centered value
	localparam int SQW  = 2 * (CW + 1) + 1;  // squared radius
	localparam int RW   = CW + 2;            // root bits
	localparam int VW   = CW + 20 + 3 + 2;   // cordic vector width
	localparam int NS   = Steps;             // cordic stages
	localparam int MSH  = 23 - $clog2(TEX_SIZE / 2);

	logic [CfgW-1:0] half_width_q, half_height_q;
	logic [TW-1:0]   dist_off_q, ang_off_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= CfgW'(400);
			half_height_q <= CfgW'(200);
			dist_off_q    <= '0;
			ang_off_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HALF_WIDTH:      half_width_q  <= cfg_data;
				REG_HALF_HEIGHT:     half_height_q <= cfg_data;
				REG_DISTANCE_OFFSET: dist_off_q    <= TW'(cfg_data);
				REG_ANGLE_OFFSET:    ang_off_q     <= TW'(cfg_data);
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: centering
	logic            v_s1;
	logic signed [DW-1:0] x_s1, y_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= $signed({2'b00, column}) - $signed(DW'(half_width_q));
			y_s1 <= $signed({2'b00, row}) - $signed(DW'(half_height_q));
		end
	end

	// stage 2: absolute values, octant fold, squared radius
	logic            v_s2, xn_s2, yn_s2;
	oct_t            oct_s2;
	logic [DW-1:0]   ax_c, ay_c;
	logic [DW-1:0]   big_s2, lit_s2;
	logic [SQW-1:0]  sq_s2;
	oct_t            oct_c;
	assign ax_c = x_s1[DW-1] ? DW'(-x_s1) : DW'(x_s1);
	assign ay_c = y_s1[DW-1] ? DW'(-y_s1) : DW'(y_s1);
	always_comb begin
		if (ax_c == '0 && ay_c == '0) oct_c = OCT_ZERO;
		else if (ay_c == '0)         oct_c = OCT_AXIS_X;
		else if (ax_c == '0)         oct_c = OCT_AXIS_Y;
		else if (ax_c == ay_c)       oct_c = OCT_DIAG;
		else if (ay_c < ax_c)        oct_c = OCT_LOW;
		else                         oct_c = OCT_HIGH;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			xn_s2  <= x_s1[DW-1];
			yn_s2  <= y_s1[DW-1];
			oct_s2 <= oct_c;
			big_s2 <= (oct_c == OCT_HIGH) ? ay_c : ax_c;
			lit_s2 <= (oct_c == OCT_HIGH) ? ax_c : ay_c;
			sq_s2  <= SQW'(ax_c) * SQW'(ax_c) + SQW'(ay_c) * SQW'(ay_c);
		end
	end

	// cordic and square root stages, one iteration each
	logic              v_c  [NS+1];
	logic              xn_c [NS+1];
	logic              yn_c [NS+1];
	oct_t              oc_c [NS+1];
	logic signed [VW-1:0] vx_c [NS+1];
	logic signed [VW-1:0] vy_c [NS+1];
	logic signed [AngW-1:0] z_c [NS+1];
	logic [SQW-1:0]    rem_c [NS+1];
	logic [RW-1:0]     rt_c  [NS+1];

	assign v_c[0]   = v_s2;
	assign xn_c[0]  = xn_s2;
	assign yn_c[0]  = yn_s2;
	assign oc_c[0]  = oct_s2;
	assign vx_c[0]  = $signed(VW'(big_s2)) <<< 20;
	assign vy_c[0]  = $signed(VW'(lit_s2)) <<< 20;
	assign z_c[0]   = '0;
	assign rem_c[0] = sq_s2;
	assign rt_c[0]  = '0;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam int RB = RW - 1 - i;   // root bit decided here, if any
		logic signed [VW-1:0]   nvx, nvy;
		logic signed [AngW-1:0] nz;
		logic [SQW-1:0]         nrem;
		logic [RW-1:0]          nrt;
		always_comb begin
			if (vy_c[i] > 0) begin
				nvx = vx_c[i] + (vy_c[i] >>> i);
				nvy = vy_c[i] - (vx_c[i] >>> i);
				nz  = z_c[i] + AngW'(atan_unit(i));
			end else begin
				nvx = vx_c[i] - (vy_c[i] >>> i);
				nvy = vy_c[i] + (vx_c[i] >>> i);
				nz  = z_c[i] - AngW'(atan_unit(i));
			end
			nrem = rem_c[i];
			nrt  = rt_c[i];
			if (RB >= 0) begin
				// trial of root bit RB against the remainder
				logic [SQW+RW:0] trial;
				trial = ((SQW+RW+1)'(rt_c[i]) << (RB + 1))
					+ ((SQW+RW+1)'(1) << (2 * RB));
				if ((SQW+RW+1)'(rem_c[i]) >= trial) begin
					nrem = SQW'((SQW+RW+1)'(rem_c[i]) - trial);
					nrt  = rt_c[i] | (RW'(1) << RB);
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_c[i+1] <= 1'b0;
			else if (adv) v_c[i+1] <= v_c[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				xn_c[i+1]  <= xn_c[i];
				yn_c[i+1]  <= yn_c[i];
				oc_c[i+1]  <= oc_c[i];
				vx_c[i+1]  <= nvx;
				vy_c[i+1]  <= nvy;
				z_c[i+1]   <= nz;
				rem_c[i+1] <= nrem;
				rt_c[i+1]  <= nrt;
			end
		end
	end

	// final stage: clamp, unfold, scale, offsets
	logic signed [AngW-1:0] zc, q, th;
	logic [TW-1:0] rad, m, ang;
	always_comb begin
		zc = z_c[NS];
		if (zc < 1) zc = AngW'(1);
		if (zc > AngW'(AngEighth - 1)) zc = AngW'(AngEighth - 1);
		case (oc_c[NS])
			OCT_AXIS_X: q = '0;
			OCT_AXIS_Y: q = AngW'(AngQuarter);
			OCT_DIAG:   q = AngW'(AngEighth);
			OCT_LOW:    q = zc;
			OCT_HIGH:   q = AngW'(AngQuarter) - zc;
			default:    q = '0;
		endcase
		th   = xn_c[NS] ? AngW'(AngHalfTurn) - q : q;
		m    = TW'(th >> MSH);
		ang  = yn_c[NS] ? TW'(-m) : m;
		rad  = TW'(rt_c[NS]);
		if (oc_c[NS] == OCT_ZERO) begin
			ang  = '0;
			rad  = '0;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_c[NS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			texture_row    <= rad + dist_off_q;
			texture_column <= ang + ang_off_q;
		end
	end

endmodule
